// ===== rtl/krs_pkg.sv =====
// shared types, constants and register codes of the keypoint smoother
package krs_pkg;

  localparam int NumPoints = 16;
  localparam int MaxTaps   = 4;
  localparam int HistDepth = (MaxTaps > 1) ? MaxTaps - 1 : 1;
  localparam int SampleW   = 24;
  localparam int CoefW     = 16;
  localparam int CoefFrac  = 14;
  localparam int IdxW      = 4;
  localparam int TapsW     = 3;
  localparam int DataW     = 24;
  localparam int CfgIdxW   = 3;
  localparam int RowW      = (NumPoints > 1) ? $clog2(NumPoints) : 1;
  localparam int UsedW     = 2;
  localparam int HistIdxW  = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int StepW     = 3;
  localparam int MacSteps  = HistDepth + 1;
  localparam int ProdW     = SampleW + CoefW;
  localparam int AccW      = ProdW + 2;
  localparam int ShW       = AccW - CoefFrac;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef sample_t [HistDepth-1:0]   axis_hist_t;
  typedef axis_hist_t [2:0]          row_t;

  localparam sample_t SampleMax   = 24'sh7fffff;
  localparam sample_t SampleMin   = 24'sh800000;
  localparam sample_t ThreshReset = -24'sd5898240;
  localparam coef_t   CoefUnity   = 16'sd16384;

  typedef struct packed {
    logic [TapsW-1:0]        taps;
    coef_t [HistDepth-1:0]   coef;
    coef_t                   coef_sample;
    sample_t                 z_thresh;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [RowW-1:0]  row;
    logic [UsedW-1:0] used;
    sample_t [2:0]    smp;
    logic             held;
  } item_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTaps       = 3'd0,
    CfgCoefOldest = 3'd1,
    CfgCoefSecond = 3'd2,
    CfgCoefThird  = 3'd3,
    CfgCoefSample = 3'd4,
    CfgThresh     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackMac,
    BackFin
  } back_state_e;

endpackage

// ===== rtl/keypoint_recursive_smoother.sv =====
// Per-keypoint recursive smoothing filter over signed Q7.16 3-D positions.
// Each item is one sample of one keypoint; a sample whose z lies below the
// invalid threshold is replaced by that keypoint's newest filtered output.
// Per axis the result is the Q1.14-weighted sum of the last taps_in_use-1
// outputs and the sample, floored to Q7.16 and saturated, and it becomes the
// newest history entry. The filter engine takes one item at a time: it reads
// the keypoint's history row from the single-port history memory, runs the
// four multiply-accumulate steps of the per-axis lanes through a product
// register, then saturates, writes the row back and loads the result register.
// A two-entry queue in front lets items be taken while the engine works.
// History reads as zero after reset; no clearing pass is needed. The user
// must write configuration only while the block is idle; it is not enforced.
module keypoint_recursive_smoother (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         point_index_i,
  input  logic signed [23:0] sample_x_i,
  input  logic signed [23:0] sample_y_i,
  input  logic signed [23:0] sample_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_index_o,
  output logic signed [23:0] filtered_x_o,
  output logic signed [23:0] filtered_y_o,
  output logic signed [23:0] filtered_z_o,
  output logic               sample_held_o,
  output logic               was_saturated_o
);
  import krs_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, head_item;
  logic  push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.taps        <= TapsW'(MaxTaps);
      cfg_q.coef        <= '0;
      cfg_q.coef_sample <= CoefUnity;
      cfg_q.z_thresh    <= ThreshReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTaps:       cfg_q.taps        <= cfg_data_i[TapsW-1:0];
        CfgCoefOldest: cfg_q.coef[0]     <= cfg_data_i[CoefW-1:0];
        CfgCoefSecond: cfg_q.coef[1]     <= cfg_data_i[CoefW-1:0];
        CfgCoefThird:  cfg_q.coef[2]     <= cfg_data_i[CoefW-1:0];
        CfgCoefSample: cfg_q.coef_sample <= cfg_data_i[CoefW-1:0];
        CfgThresh:     cfg_q.z_thresh    <= cfg_data_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  krs_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_index_i (point_index_i),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .sample_z_i    (sample_z_i),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  krs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  krs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_item_i        (head_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_index_o     (out_index_o),
    .filtered_x_o    (filtered_x_o),
    .filtered_y_o    (filtered_y_o),
    .filtered_z_o    (filtered_z_o),
    .sample_held_o   (sample_held_o),
    .was_saturated_o (was_saturated_o)
  );

endmodule

// ===== rtl/krs_front.sv =====
// input side: takes an item, flags invalid samples and clamps the tap count
module krs_front (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3:0]              point_index_i,
  input  logic signed [23:0]      sample_x_i,
  input  logic signed [23:0]      sample_y_i,
  input  logic signed [23:0]      sample_z_i,
  input  krs_pkg::cfg_t           cfg_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output krs_pkg::item_t          item_o
);
  import krs_pkg::*;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.idx    = point_index_i;
    item_o.row    = RowW'(point_index_i % NumPoints);
    item_o.smp[0] = sample_x_i;
    item_o.smp[1] = sample_y_i;
    item_o.smp[2] = sample_z_i;
    item_o.held   = $signed(sample_z_i) < $signed(cfg_i.z_thresh);
    // zero taps acts as one, anything above the maximum as the maximum
    priority if (cfg_i.taps == '0) begin
      item_o.used = '0;
    end else if (cfg_i.taps > TapsW'(MaxTaps)) begin
      item_o.used = UsedW'(MaxTaps - 1);
    end else begin
      item_o.used = UsedW'(cfg_i.taps - TapsW'(1));
    end
  end

endmodule

// ===== rtl/krs_queue.sv =====
// two-entry queue of classified items between front and back
module krs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  krs_pkg::item_t item_i,
  input  logic           pop_i,
  output krs_pkg::item_t item_o,
  output logic           full_o,
  output logic           empty_o
);
  import krs_pkg::*;

  item_t [1:0] slot_q;
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

endmodule

// ===== rtl/krs_back.sv =====
// filter engine: history memory, one multiply-accumulate lane per axis, result register
module krs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  krs_pkg::cfg_t       cfg_i,
  input  logic                q_empty_i,
  input  krs_pkg::item_t      q_item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          out_index_o,
  output logic signed [23:0]  filtered_x_o,
  output logic signed [23:0]  filtered_y_o,
  output logic signed [23:0]  filtered_z_o,
  output logic                sample_held_o,
  output logic                was_saturated_o
);
  import krs_pkg::*;

  back_state_e state_q, state_d;
  logic [StepW-1:0] step_q;
  item_t  item_q;
  row_t   mem [NumPoints];
  row_t   rd_q, hist, new_row;
  logic   rvalid_q;
  logic [NumPoints-1:0] row_valid_q;

  logic signed [ProdW-1:0] prod_q [3];
  logic signed [ProdW-1:0] prod_d [3];
  logic signed [AccW-1:0]  acc_q [3];
  logic signed [AccW-1:0]  acc_d [3];
  coef_t   c_op [3];
  sample_t s_op [3];
  logic [StepW-1:0] hidx;
  logic    in_use;

  logic signed [ShW-1:0] shifted [3];
  sample_t res [3];
  logic [2:0] sat;
  logic mac_en, fin_go;

  // rows never written since reset read as zero
  assign hist = rvalid_q ? rd_q : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BackIdle: if (!q_empty_i) state_d = BackMac;
      BackMac:  if (step_q == StepW'(MacSteps)) state_d = BackFin;
      BackFin:  if (!out_valid_o || out_ready_i) state_d = BackIdle;
      default:  state_d = BackIdle;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o  = 1'b0;
    mac_en = 1'b0;
    fin_go = 1'b0;
    unique case (state_q)
      BackIdle: pop_o  = !q_empty_i;
      BackMac:  mac_en = 1'b1;
      BackFin:  fin_go = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  // operand selection: stored taps oldest first, then the sample
  always_comb begin
    hidx   = StepW'(HistDepth) - StepW'(item_q.used) + step_q;
    in_use = step_q < StepW'(item_q.used);
    for (int a = 0; a < 3; a++) begin
      c_op[a] = '0;
      s_op[a] = '0;
      if (step_q < StepW'(HistDepth)) begin
        if (in_use) begin
          c_op[a] = cfg_i.coef[step_q[HistIdxW-1:0]];
          s_op[a] = hist[a][hidx[HistIdxW-1:0]];
        end
      end else begin
        c_op[a] = cfg_i.coef_sample;
        s_op[a] = item_q.held ? hist[a][HistDepth-1] : item_q.smp[a];
      end
      prod_d[a] = c_op[a] * s_op[a];
      if (step_q == '0) begin
        acc_d[a] = '0;
      end else begin
        acc_d[a] = acc_q[a] + AccW'(prod_q[a]);
      end
    end
  end

  // floor shift, saturation and history shift
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      shifted[a] = ShW'(acc_q[a] >>> CoefFrac);
      if (&shifted[a][ShW-1:SampleW-1] || ~|shifted[a][ShW-1:SampleW-1]) begin
        res[a] = shifted[a][SampleW-1:0];
        sat[a] = 1'b0;
      end else begin
        res[a] = shifted[a][ShW-1] ? SampleMin : SampleMax;
        sat[a] = 1'b1;
      end
      for (int k = 0; k < HistDepth - 1; k++) begin
        new_row[a][k] = hist[a][k+1];
      end
      new_row[a][HistDepth-1] = res[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      step_q      <= '0;
      rvalid_q    <= 1'b0;
      row_valid_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q   <= '0;
        rvalid_q <= row_valid_q[q_item_i.row];
      end else if (mac_en) begin
        step_q <= step_q + StepW'(1);
      end
      if (fin_go) begin
        row_valid_q[item_q.row] <= 1'b1;
        out_valid_o             <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
      rd_q   <= mem[q_item_i.row];
    end
    if (fin_go) mem[item_q.row] <= new_row;
  end

  always_ff @(posedge clk_i) begin
    if (mac_en) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= prod_d[a];
        acc_q[a]  <= acc_d[a];
      end
    end
    if (fin_go) begin
      out_index_o     <= item_q.idx;
      filtered_x_o    <= res[0];
      filtered_y_o    <= res[1];
      filtered_z_o    <= res[2];
      sample_held_o   <= item_q.held;
      was_saturated_o <= |sat;
    end
  end

endmodule

// ===== tb/sv/krs_filter_checker.sv =====
// predicts the smoother's filtered outputs and checks them against the dut
module krs_filter_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [3:0]         point_index_i,
  input  logic signed [23:0] sample_x_i,
  input  logic signed [23:0] sample_y_i,
  input  logic signed [23:0] sample_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [3:0]         out_index_i,
  input  logic signed [23:0] filtered_x_i,
  input  logic signed [23:0] filtered_y_i,
  input  logic signed [23:0] filtered_z_i,
  input  logic               sample_held_i,
  input  logic               was_saturated_i,
  output int                 mismatch_count_o,
  output int                 awaiting_o
);
  import krs_pkg::*;

  typedef struct {
    logic [IdxW-1:0] idx;
    sample_t         x;
    sample_t         y;
    sample_t         z;
    logic            held;
    logic            sat;
  } filtered_t;

  // filter settings as the dut should hold them
  logic [TapsW-1:0] taps_cfg;
  coef_t            hist_coef [HistDepth];
  coef_t            sample_coef;
  sample_t          z_thresh;

  // per keypoint and axis, oldest output first
  sample_t   point_history [NumPoints][3][HistDepth];
  filtered_t filtered_q [$];
  int        mismatches;

  assign mismatch_count_o = mismatches;

  function automatic filtered_t smooth_sample(logic [IdxW-1:0] idx, sample_t sx, sample_t sy,
                                              sample_t sz);
    filtered_t res;
    sample_t   smp [3];
    int        row;
    int        taps;
    int        used;
    int        first;
    int        a;
    int        k;
    longint    acc;
    longint    fl;
    row      = int'(idx) % NumPoints;
    res.idx  = idx;
    res.held = (sz < z_thresh);
    res.sat  = 1'b0;
    smp[0]   = sx;
    smp[1]   = sy;
    smp[2]   = sz;
    taps  = (taps_cfg == 0) ? 1 : ((int'(taps_cfg) > MaxTaps) ? MaxTaps : int'(taps_cfg));
    used  = taps - 1;
    first = HistDepth - used;
    for (a = 0; a < 3; a++) begin
      if (res.held) begin
        smp[a] = point_history[row][a][HistDepth-1];
      end
      acc = longint'(sample_coef) * longint'(smp[a]);
      for (k = 0; k < used; k++) begin
        acc += longint'(hist_coef[k]) * longint'(point_history[row][a][first+k]);
      end
      // floor to q7.16, then clip
      fl = acc >>> CoefFrac;
      if (fl > longint'(SampleMax)) begin
        fl = longint'(SampleMax);
        res.sat = 1'b1;
      end else if (fl < longint'(SampleMin)) begin
        fl = longint'(SampleMin);
        res.sat = 1'b1;
      end
      for (k = 0; k < HistDepth - 1; k++) begin
        point_history[row][a][k] = point_history[row][a][k+1];
      end
      point_history[row][a][HistDepth-1] = sample_t'(fl);
      smp[a] = sample_t'(fl);
    end
    res.x = smp[0];
    res.y = smp[1];
    res.z = smp[2];
    return res;
  endfunction

  function automatic void check_field(string name, logic signed [23:0] want,
                                      logic signed [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t want;
    if (!rst_ni) begin
      taps_cfg    = TapsW'(MaxTaps);
      sample_coef = CoefUnity;
      z_thresh    = ThreshReset;
      foreach (hist_coef[k]) hist_coef[k] = '0;
      foreach (point_history[p, a, k]) point_history[p][a][k] = '0;
      filtered_q.delete();
      mismatches  = 0;
      awaiting_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgTaps:       taps_cfg     = cfg_data_i[TapsW-1:0];
          CfgCoefOldest: hist_coef[0] = coef_t'(cfg_data_i[CoefW-1:0]);
          CfgCoefSecond: hist_coef[1] = coef_t'(cfg_data_i[CoefW-1:0]);
          CfgCoefThird:  hist_coef[2] = coef_t'(cfg_data_i[CoefW-1:0]);
          CfgCoefSample: sample_coef  = coef_t'(cfg_data_i[CoefW-1:0]);
          CfgThresh:     z_thresh     = sample_t'(cfg_data_i);
          default: ;
        endcase
      end
      // results are checked before this edge's item is queued
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none actual point %0d", $time, out_index_i);
        end else begin
          want = filtered_q.pop_front();
          check_field("out_index", 24'(want.idx), 24'(out_index_i));
          check_field("filtered_x", want.x, filtered_x_i);
          check_field("filtered_y", want.y, filtered_y_i);
          check_field("filtered_z", want.z, filtered_z_i);
          check_field("sample_held", 24'(want.held), 24'(sample_held_i));
          check_field("was_saturated", 24'(want.sat), 24'(was_saturated_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        filtered_q.push_back(smooth_sample(point_index_i, sample_x_i, sample_y_i, sample_z_i));
      end
      awaiting_o = filtered_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_keypoint_recursive_smoother.sv =====
// stimulus and verdict for the keypoint recursive smoother
module tb_keypoint_recursive_smoother;
  import krs_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         point_index = '0;
  logic signed [23:0] sample_x = '0;
  logic signed [23:0] sample_y = '0;
  logic signed [23:0] sample_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_index;
  logic signed [23:0] filtered_x;
  logic signed [23:0] filtered_y;
  logic signed [23:0] filtered_z;
  logic               sample_held;
  logic               was_saturated;

  int                 mismatches;
  int                 awaiting;
  logic               idle_on = 1'b0;
  logic               stall_on = 1'b0;
  int unsigned        hold_left = 0;
  sample_t            cur_thresh = ThreshReset;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keypoint_recursive_smoother dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .point_index_i  (point_index),
    .sample_x_i     (sample_x),
    .sample_y_i     (sample_y),
    .sample_z_i     (sample_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_index_o    (out_index),
    .filtered_x_o   (filtered_x),
    .filtered_y_o   (filtered_y),
    .filtered_z_o   (filtered_z),
    .sample_held_o  (sample_held),
    .was_saturated_o(was_saturated)
  );

  krs_filter_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .point_index_i   (point_index),
    .sample_x_i      (sample_x),
    .sample_y_i      (sample_y),
    .sample_z_i      (sample_z),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_index_i     (out_index),
    .filtered_x_i    (filtered_x),
    .filtered_y_i    (filtered_y),
    .filtered_z_i    (filtered_z),
    .sample_held_i   (sample_held),
    .was_saturated_i (was_saturated),
    .mismatch_count_o(mismatches),
    .awaiting_o      (awaiting)
  );

  // mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SampleMax;
      1: return SampleMin;
      2, 3, 4: return sample_t'(longint'($urandom_range(0, 1 << 17)) - (1 << 16));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // z often lands right around the invalid threshold
  function automatic sample_t rand_z();
    longint t;
    if ($urandom_range(0, 4) != 0) return rand_sample();
    t = longint'(cur_thresh) + longint'($urandom_range(0, 4)) - 2;
    if (t > longint'(SampleMax)) t = longint'(SampleMax);
    if (t < longint'(SampleMin)) t = longint'(SampleMin);
    return sample_t'(t);
  endfunction

  function automatic coef_t extreme_coef();
    case ($urandom_range(0, 3))
      0: return coef_t'(16'sh8000);
      1: return coef_t'(16'sh7fff);
      2: return '0;
      default: return CoefUnity;
    endcase
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!stall_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'($urandom_range(0, 1));
      hold_left <= pick_gap();
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [23:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // only called at a falling edge; waits for the filter to drain first
  task automatic set_filter(logic [TapsW-1:0] taps, coef_t c0, coef_t c1, coef_t c2,
                            coef_t cs, sample_t thr);
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    // unused upper data bits carry noise
    write_reg(CfgTaps, {21'($urandom), taps});
    write_reg(CfgCoefOldest, {8'($urandom), c0});
    write_reg(CfgCoefSecond, {8'($urandom), c1});
    write_reg(CfgSpare, 24'($urandom));
    write_reg(CfgCoefThird, {8'($urandom), c2});
    write_reg(CfgCoefSample, {8'($urandom), cs});
    write_reg(CfgThresh, thr);
    cfg_valid  = 1'b0;
    cur_thresh = thr;
  endtask

  task automatic send_sample(logic [3:0] idx, sample_t x, sample_t y, sample_t z);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_index = idx;
    sample_x    = x;
    sample_y    = y;
    sample_z    = z;
    in_valid    = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int               phase;
    int               n;
    logic [TapsW-1:0] taps;
    coef_t            c [4];
    sample_t          thr;
    int               sum;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n    = 1'b1;
    idle_on  = 1'b1;
    stall_on = 1'b1;

    // reset settings pass samples through unchanged unless they are held
    send_sample(4'd0, SampleMax, SampleMin, '0);
    send_sample(4'd15, SampleMin, SampleMax, SampleMax);
    send_sample(4'd0, 24'sd1, -24'sd1, ThreshReset);
    send_sample(4'd0, 24'sd123, 24'sd456, sample_t'(ThreshReset - 1));
    send_sample(4'd15, '0, '0, SampleMin);
    // untouched keypoint held: its history is still zero
    send_sample(4'd5, SampleMax, SampleMax, SampleMin);

    // extreme weights drive the sums into saturation
    set_filter(3'd4, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, SampleMin);
    send_sample(4'd15, SampleMin, SampleMax, SampleMin);
    send_sample(4'd15, SampleMax, SampleMin, '0);
    send_sample(4'd0, SampleMin, SampleMin, SampleMin);
    send_sample(4'd0, -24'sd1, '0, 24'sd1);

    // zero taps behaves as a single tap
    set_filter(3'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, SampleMax);
    send_sample(4'd3, 24'sd1000, -24'sd1000, SampleMax);
    send_sample(4'd3, 24'sd5, 24'sd5, '0);
    send_sample(4'd3, SampleMin, SampleMax, sample_t'(SampleMax - 1));

    // taps above the maximum behave as the maximum
    set_filter(3'd7, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096, ThreshReset);
    send_sample(4'd7, 24'sd65536, -24'sd65536, 24'sd131072);
    send_sample(4'd7, SampleMax, SampleMax, SampleMax);
    send_sample(4'd7, '0, '0, SampleMin);

    // single tap: history still shifts so holding sees the newest output
    set_filter(3'd1, 16'sh8000, 16'sh8000, 16'sh8000, CoefUnity, '0);
    send_sample(4'd2, 24'sd777, -24'sd777, '0);
    send_sample(4'd2, 24'sd1, 24'sd1, -24'sd1);

    set_filter(3'd2, '0, '0, CoefUnity, 16'sd8192, ThreshReset);
    send_sample(4'd9, 24'sd300000, -24'sd300000, 24'sd100);
    send_sample(4'd9, 24'sd300000, -24'sd300000, 24'sd100);

    set_filter(3'd3, '0, -16'sd8192, 16'sd8192, CoefUnity, ThreshReset);
    send_sample(4'd9, 24'sd12345, -24'sd54321, 24'sd999);
    send_sample(4'd9, SampleMax, SampleMin, SampleMin);

    for (phase = 0; phase < 8; phase++) begin
      in_valid = 1'b0;
      idle_on  = (phase % 3) != 2;
      stall_on = (phase % 4) != 1;
      taps     = ($urandom_range(0, 9) < 7) ? TapsW'($urandom_range(1, 4))
                                            : TapsW'($urandom_range(0, 7));
      case ($urandom_range(0, 2))
        0: begin
          // well-behaved smoothing: weights add up to unity
          sum = 0;
          for (n = 0; n < 3; n++) begin
            c[n] = coef_t'($urandom_range(0, 5000));
            sum += int'(c[n]);
          end
          c[3] = coef_t'(int'(CoefUnity) - sum);
        end
        1: for (n = 0; n < 4; n++) c[n] = coef_t'($urandom);
        default: for (n = 0; n < 4; n++) c[n] = extreme_coef();
      endcase
      case ($urandom_range(0, 4))
        0: thr = ThreshReset;
        1: thr = sample_t'($urandom);
        2: thr = SampleMin;
        3: thr = SampleMax;
        default: thr = sample_t'(longint'($urandom_range(0, 2000)) - 1000);
      endcase
      set_filter(taps, c[0], c[1], c[2], c[3], thr);
      for (n = 0; n < 140; n++) begin
        // in even phases three keypoints at a time build deep histories; odd phases use all 16
        send_sample((phase % 2) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2)),
                    rand_sample(), rand_sample(), rand_z());
      end
    end

    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/krs_pkg.sv
rtl/krs_front.sv
rtl/krs_queue.sv
rtl/krs_back.sv
rtl/keypoint_recursive_smoother.sv
tb/sv/krs_filter_checker.sv
tb/sv/tb_keypoint_recursive_smoother.sv
